// ===== design/spa_pkg.sv =====
package spa_pkg;

    localparam int NUM_ENTRIES_DEF = 16;

    localparam int OP_W  = 3;
    localparam int IDX_W = 4;
    localparam int VAL_W = 32;
    localparam int SUM_W = 64;
    localparam int CNT_W = 32;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 392;

    localparam logic [OP_W-1:0] OP_SET   = 3'd0;
    localparam logic [OP_W-1:0] OP_INC   = 3'd1;
    localparam logic [OP_W-1:0] OP_DEC   = 3'd2;
    localparam logic [OP_W-1:0] OP_FLUSH = 3'd3;
    localparam logic [OP_W-1:0] OP_RESET = 3'd4;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // packed from the lowest bit up: opcode, item_index, value
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        item_index;
        logic [OP_W-1:0]         opcode;
    } t_item;

    // packed from the lowest bit up: last, min, max, sum, count
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [SUM_W-1:0] sum;
        logic signed [VAL_W-1:0] max_val;
        logic signed [VAL_W-1:0] min_val;
        logic signed [VAL_W-1:0] last;
    } t_period;

    typedef struct packed {
        t_period rep;
        t_period cur;
    } t_entry;

endpackage

// ===== design/stat_period_accumulator.sv =====
// Channel   Direction  Handshake               Payload
// s         in         i_s_tvalid/o_s_tready   i_s_tdata: opcode, item_index, value
// m         out        o_m_tvalid/i_m_tready   o_m_tdata: out_index, cur_*, rep_*
// cfg       in         i_cfg_we                i_cfg_wdata: entry reset value
//
// One item per cycle sustained while the output is not stalled; an accepted item waits
// in the input register, and the update stage does a single read-modify-write of the
// entry registers that writes back at the same edge that loads the result register.
// Synchronous reset clears all entries to zero and empties both stages.
// A stalled result holds in the output register; the input stage still takes an item
// whenever it is empty or the result register is free or being taken in the same cycle.
module stat_period_accumulator #(
    parameter int NUM_ENTRIES = spa_pkg::NUM_ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // opcode[2:0], item_index[6:3], value[38:7], zero[39]
    input  logic [spa_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // out_index[3:0], cur_last[35:4], cur_min[67:36], cur_max[99:68],
    // cur_sum[163:100], cur_count[195:164], rep_last[227:196], rep_min[259:228],
    // rep_max[291:260], rep_sum[355:292], rep_count[387:356], zero[391:388]
    output logic [spa_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input  logic                            i_cfg_we,
    input  logic [spa_pkg::VAL_W-1:0]       i_cfg_wdata
);

    localparam int IDX_SPAN = 2 ** spa_pkg::IDX_W;
    localparam int DEPTH    = (NUM_ENTRIES < IDX_SPAN) ? NUM_ENTRIES : IDX_SPAN;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ITEM_W   = $bits(spa_pkg::t_item);
    localparam int OUT_PAD  = spa_pkg::OUT_TDATA_W - $bits(spa_pkg::t_entry) - spa_pkg::IDX_W;

    spa_pkg::t_entry                  r_entry [DEPTH];
    logic signed [spa_pkg::VAL_W-1:0] r_default;
    logic                             r_v1;
    spa_pkg::t_item                   r_item;
    logic                             r_ov;
    logic [spa_pkg::OUT_TDATA_W-1:0]  r_out;

    logic                             adv;
    logic                             in_range;
    logic [AW-1:0]                    addr;
    spa_pkg::t_entry                  old_entry;
    spa_pkg::t_entry                  n_entry;
    spa_pkg::t_entry                  n_out_entry;

    assign adv        = r_v1 && (!r_ov || i_m_tready);
    assign o_s_tready = !r_v1 || adv;
    assign in_range   = int'(r_item.item_index) < DEPTH;
    assign addr       = r_item.item_index[AW-1:0];
    assign old_entry  = in_range ? r_entry[addr] : '0;

    spa_update u_update (
        .i_item    (r_item),
        .i_entry   (old_entry),
        .i_default (r_default),
        .o_entry   (n_entry)
    );

    assign n_out_entry = in_range ? n_entry : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_ov      <= 1'b0;
            r_default <= '0;
            for (int i = 0; i < DEPTH; i++) begin
                r_entry[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_default <= i_cfg_wdata;
            end
            if (o_s_tready) begin
                r_v1 <= i_s_tvalid;
            end
            if (i_s_tvalid && o_s_tready) begin
                r_item <= spa_pkg::t_item'(i_s_tdata[ITEM_W-1:0]);
            end
            if (adv) begin
                r_ov  <= 1'b1;
                r_out <= {{OUT_PAD{1'b0}}, n_out_entry, r_item.item_index};
                if (in_range) begin
                    r_entry[addr] <= n_entry;
                end
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_out;

endmodule

// ===== design/spa_update.sv =====
module spa_update (
    input  spa_pkg::t_item                 i_item,
    input  spa_pkg::t_entry                i_entry,
    input  logic signed [spa_pkg::VAL_W-1:0] i_default,
    output spa_pkg::t_entry                o_entry
);

    logic signed [spa_pkg::VAL_W-1:0] sample;
    logic signed [spa_pkg::SUM_W-1:0] sample_ext;

    always_comb begin
        case (i_item.opcode)
            spa_pkg::OP_INC: begin
                sample = i_entry.cur.last + i_item.value;
            end
            spa_pkg::OP_DEC: begin
                sample = i_entry.cur.last - i_item.value;
            end
            default: begin
                sample = i_item.value;
            end
        endcase
    end

    assign sample_ext = {{(spa_pkg::SUM_W-spa_pkg::VAL_W){sample[spa_pkg::VAL_W-1]}}, sample};

    always_comb begin
        o_entry = i_entry;
        case (i_item.opcode)
            spa_pkg::OP_SET, spa_pkg::OP_INC, spa_pkg::OP_DEC: begin
                o_entry.cur.last = sample;
                if (i_entry.cur.count == '0) begin
                    o_entry.cur.min_val = sample;
                    o_entry.cur.max_val = sample;
                    o_entry.cur.sum     = sample_ext;
                    o_entry.cur.count   = spa_pkg::CNT_W'(1);
                end else begin
                    if (sample < i_entry.cur.min_val) begin
                        o_entry.cur.min_val = sample;
                    end
                    if (i_entry.cur.max_val < sample) begin
                        o_entry.cur.max_val = sample;
                    end
                    o_entry.cur.sum = i_entry.cur.sum + sample_ext;
                    if (i_entry.cur.count != spa_pkg::CNT_MAX) begin
                        o_entry.cur.count = i_entry.cur.count + spa_pkg::CNT_W'(1);
                    end
                end
            end
            spa_pkg::OP_FLUSH: begin
                o_entry.rep         = i_entry.cur;
                o_entry.cur.sum     = '0;
                o_entry.cur.count   = '0;
                o_entry.cur.min_val = i_entry.cur.last;
                o_entry.cur.max_val = i_entry.cur.last;
            end
            spa_pkg::OP_RESET: begin
                o_entry.cur.sum     = '0;
                o_entry.cur.count   = '0;
                o_entry.cur.last    = i_default;
                o_entry.cur.min_val = i_default;
                o_entry.cur.max_val = i_default;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== design/spa_checker.sv =====
module spa_checker #(
    parameter int NUM_ENTRIES = spa_pkg::NUM_ENTRIES_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [spa_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed or dropped");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (int'(o_m_tdata[3:0]) >= NUM_ENTRIES) |-> o_m_tdata[387:4] == '0)
        else $error("missing entry reported nonzero values");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[195:164] == '0) |->
            (o_m_tdata[163:100] == '0) && (o_m_tdata[67:36] == o_m_tdata[35:4]) &&
            (o_m_tdata[99:68] == o_m_tdata[35:4]))
        else $error("empty period with stale sum or bounds");

    a_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[195:164] != '0) |->
            ($signed(o_m_tdata[67:36]) <= $signed(o_m_tdata[35:4])) &&
            ($signed(o_m_tdata[35:4]) <= $signed(o_m_tdata[99:68])))
        else $error("last outside period min and max");

endmodule

bind stat_period_accumulator spa_checker #(.NUM_ENTRIES(NUM_ENTRIES)) u_spa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
